[src/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg: shared types, constants and classification for the tokenizer
// Holds the token record, type codes, delimiter test and keyword table.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

    // Field widths and limits
    localparam int MAX_TOKEN   = 35;
    localparam int LEN_W       = 6;
    localparam int COL_W       = 16;
    localparam int LINE_W      = 20;
    localparam int CH_W        = 8;
    localparam int TYPE_W      = 6;
    localparam int HEAD_BYTES  = 8;
    localparam int HEAD_W      = HEAD_BYTES * CH_W;
    localparam int QUEUE_DEPTH = 4;

    // Comment / literal tracking
    localparam logic [1:0] QM_NONE    = 2'd0;
    localparam logic [1:0] QM_COMMENT = 2'd1;
    localparam logic [1:0] QM_LITERAL = 2'd2;

    // Characters with special meaning
    localparam logic [CH_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [CH_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [CH_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_EQ    = 8'h3D;

    // Token type codes
    localparam logic [TYPE_W-1:0] TT_LBRACE   = 6'd0;
    localparam logic [TYPE_W-1:0] TT_RBRACE   = 6'd1;
    localparam logic [TYPE_W-1:0] TT_LBRACKET = 6'd2;
    localparam logic [TYPE_W-1:0] TT_RBRACKET = 6'd3;
    localparam logic [TYPE_W-1:0] TT_LPAREN   = 6'd4;
    localparam logic [TYPE_W-1:0] TT_RPAREN   = 6'd5;
    localparam logic [TYPE_W-1:0] TT_DOT      = 6'd6;
    localparam logic [TYPE_W-1:0] TT_COMMA    = 6'd7;
    localparam logic [TYPE_W-1:0] TT_COLON    = 6'd8;
    localparam logic [TYPE_W-1:0] TT_SEMI     = 6'd9;
    localparam logic [TYPE_W-1:0] TT_EQUALS   = 6'd10;
    localparam logic [TYPE_W-1:0] TT_TAB      = 6'd11;
    localparam logic [TYPE_W-1:0] TT_SPACE    = 6'd12;
    localparam logic [TYPE_W-1:0] TT_NEWLINE  = 6'd13;
    localparam int                TT_KW_BASE  = 14;
    localparam logic [TYPE_W-1:0] TT_COMMENT  = 6'd33;
    localparam logic [TYPE_W-1:0] TT_LITERAL  = 6'd34;
    localparam logic [TYPE_W-1:0] TT_IDENT    = 6'd35;

    // Keyword table: text right-aligned, first character in the top used byte
    localparam int KW_COUNT = 19;
    localparam logic [HEAD_W-1:0] KW_TEXT [KW_COUNT] = '{
        "include", "byte", "char", "int", "prec", "bool", "true", "false",
        "string", "function", "returns", "return", "while", "still", "do",
        "loop", "for", "static", "end"
    };
    localparam int KW_LEN [KW_COUNT] = '{
        7, 4, 4, 3, 4, 4, 4, 5, 6, 8, 7, 6, 5, 5, 2, 4, 3, 6, 3
    };

    // Raw token record: held bytes (first character lowest) plus metadata
    typedef struct packed {
        logic [HEAD_W-1:0] head;
        logic [LEN_W-1:0]  len;
        logic [COL_W-1:0]  col;
        logic [LINE_W-1:0] line;
        logic              cut;
        logic              last;
        logic              tilde;
        logic              quote;
    } t_raw;

    // Records pushed by the scanner in one cycle, first before second
    typedef struct packed {
        logic first;
        logic second;
    } t_push;

    function automatic logic is_delim(input logic [CH_W-1:0] c);
        logic d;
        unique case (c)
            "{", "}", "[", "]", "(", ")", ".", ",", ":", ";",
            "+", "-", "*", "/", "^", ">", "<",
            CH_TAB, CH_SPACE, CH_NL: d = 1'b1;
            default:                 d = 1'b0;
        endcase
        return d;
    endfunction

    function automatic logic kw_match(input logic [HEAD_W-1:0] head,
                                      input logic [LEN_W-1:0]  len,
                                      input int                k);
        logic ok;
        ok = (len == LEN_W'(KW_LEN[k]));
        for (int j = 0; j < HEAD_BYTES; j++) begin
            if (j < KW_LEN[k]) begin
                ok = ok && (head[CH_W*j +: CH_W] ==
                            KW_TEXT[k][CH_W*(KW_LEN[k]-1-j) +: CH_W]);
            end
        end
        return ok;
    endfunction

    function automatic logic [TYPE_W-1:0] classify(input t_raw r);
        logic [TYPE_W-1:0] t;
        t = r.tilde ? TT_COMMENT : (r.quote ? TT_LITERAL : TT_IDENT);
        // Earlier keywords win, so scan from the back and overwrite
        if (r.len <= LEN_W'(HEAD_BYTES)) begin
            for (int k = KW_COUNT - 1; k >= 0; k--) begin
                if (kw_match(r.head, r.len, k)) begin
                    t = TYPE_W'(TT_KW_BASE + k);
                end
            end
        end
        // Single-character punctuation and whitespace
        if (r.len == LEN_W'(1)) begin
            unique case (r.head[CH_W-1:0])
                "{":      t = TT_LBRACE;
                "}":      t = TT_RBRACE;
                "[":      t = TT_LBRACKET;
                "]":      t = TT_RBRACKET;
                "(":      t = TT_LPAREN;
                ")":      t = TT_RPAREN;
                ".":      t = TT_DOT;
                ",":      t = TT_COMMA;
                ":":      t = TT_COLON;
                ";":      t = TT_SEMI;
                CH_EQ:    t = TT_EQUALS;
                CH_TAB:   t = TT_TAB;
                CH_SPACE: t = TT_SPACE;
                CH_NL:    t = TT_NEWLINE;
                default:  t = t;
            endcase
        end
        return t;
    endfunction

endpackage

`default_nettype wire

[src/source_text_tokenizer_top.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer_top: source text tokenizer
// Tokens pass through the 4-deep queue and then the single output register.
// Throughput: one character per cycle while o_stall is low; a character that
// ends two tokens pushes two records, which are presented one after another.
// Reset (synchronous, active low) clears all token state and the line to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [stt_pkg::CH_W-1:0]    i_ch,
    input  wire logic                        i_end_of_text,
    input  wire logic                        i_cfg_we,
    input  wire logic [stt_pkg::LINE_W-1:0]  i_cfg_wdata,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [stt_pkg::TYPE_W-1:0]       o_token_type,
    output logic [stt_pkg::LEN_W-1:0]        o_token_length,
    output logic [stt_pkg::COL_W-1:0]        o_token_column,
    output logic [stt_pkg::LINE_W-1:0]       o_token_line,
    output logic                             o_was_cut,
    output logic                             o_last_token
);
    import stt_pkg::*;

    t_push push;
    t_raw  rec0, rec1, head;
    logic  take, nonempty, busy, pop;

    // Accept a character transfer while the queue has room for two records
    assign o_stall = busy;
    assign take    = i_valid && !busy;

    stt_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_ch        (i_ch),
        .i_eot       (i_end_of_text),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (push),
        .o_rec0      (rec0),
        .o_rec1      (rec1)
    );

    stt_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_rec0     (rec0),
        .i_rec1     (rec1),
        .i_pop      (pop),
        .o_head     (head),
        .o_nonempty (nonempty),
        .o_busy     (busy)
    );

    stt_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_nonempty     (nonempty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_type   (o_token_type),
        .o_token_length (o_token_length),
        .o_token_column (o_token_column),
        .o_token_line   (o_token_line),
        .o_was_cut      (o_was_cut),
        .o_last_token   (o_last_token)
    );

endmodule

`default_nettype wire

[src/stt_scan.sv]
// ----------------------------------------------------------------------------
// stt_scan: character scanner
// Holds the pending token and position state, finds boundaries and cuts,
// and produces up to two raw token records per accepted character.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_scan (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_take,
    input  wire logic [stt_pkg::CH_W-1:0]    i_ch,
    input  wire logic                        i_eot,
    input  wire logic                        i_cfg_we,
    input  wire logic [stt_pkg::LINE_W-1:0]  i_cfg_wdata,
    output stt_pkg::t_push                   o_push,
    output stt_pkg::t_raw                    o_rec0,
    output stt_pkg::t_raw                    o_rec1
);
    import stt_pkg::*;

    logic [HEAD_W-1:0] r_head, n_head;
    logic [LEN_W-1:0]  r_pl, n_pl;
    logic [CH_W-1:0]   r_prev, n_prev;
    logic [1:0]        r_qm, n_qm;
    logic              r_st, n_st;
    logic              r_sq, n_sq;
    logic [COL_W-1:0]  r_tsc, n_tsc;
    logic [COL_W-1:0]  r_cc, n_cc;
    logic [LINE_W-1:0] r_ln, n_ln;

    logic              boundary, cut, emit1;
    logic [COL_W:0]    col_sum1, col_sum2;
    logic [COL_W-1:0]  cc1, cc2;
    logic [LEN_W-1:0]  pl1, pl2;
    logic [HEAD_W-1:0] head1, head2;
    logic              st1, sq1, st2, sq2;
    logic [1:0]        qm2;
    logic [LINE_W-1:0] ln2;
    logic [COL_W-1:0]  tsc2;
    t_raw              rec_a, rec_b;

    always_comb begin
        // Boundary or length cut against the pending token
        boundary = (r_pl != '0) && (r_qm == QM_NONE) &&
                   (is_delim(r_prev) || is_delim(i_ch));
        cut      = (r_pl != '0) && !boundary && (r_pl >= LEN_W'(MAX_TOKEN));
        emit1    = boundary || cut;

        rec_a.head  = r_head;
        rec_a.len   = r_pl;
        rec_a.col   = r_tsc;
        rec_a.line  = r_ln;
        rec_a.cut   = cut;
        rec_a.last  = 1'b0;
        rec_a.tilde = r_st;
        rec_a.quote = r_sq;

        // Retire the first token
        col_sum1 = {1'b0, r_cc} + (COL_W+1)'(r_pl);
        if (emit1) begin
            cc1   = col_sum1[COL_W] ? '1 : col_sum1[COL_W-1:0];
            pl1   = '0;
            head1 = '0;
            st1   = cut && (r_qm == QM_COMMENT);
            sq1   = cut && (r_qm == QM_LITERAL);
        end else begin
            cc1   = r_cc;
            pl1   = r_pl;
            head1 = r_head;
            st1   = r_st;
            sq1   = r_sq;
        end

        // Take the character
        cc2  = cc1;
        ln2  = r_ln;
        tsc2 = r_tsc;
        if (pl1 == '0) begin
            if (i_ch == CH_NL) begin
                ln2 = (r_ln == '1) ? r_ln : r_ln + LINE_W'(1);
                cc2 = '0;
            end
            tsc2 = cc2;
        end
        head2 = head1;
        if (pl1 < LEN_W'(HEAD_BYTES)) begin
            head2 = head1 | ({{(HEAD_W-CH_W){1'b0}}, i_ch} << {pl1[2:0], 3'b000});
        end
        pl2 = pl1 + LEN_W'(1);

        qm2 = r_qm;
        priority if (r_qm == QM_NONE) begin
            if (i_ch == CH_TILDE)      qm2 = QM_COMMENT;
            else if (i_ch == CH_QUOTE) qm2 = QM_LITERAL;
        end else if (r_qm == QM_COMMENT && i_ch == CH_TILDE) begin
            qm2 = QM_NONE;
        end else if (r_qm == QM_LITERAL && i_ch == CH_QUOTE) begin
            qm2 = QM_NONE;
        end else begin
            qm2 = r_qm;
        end
        st2 = st1 || (i_ch == CH_TILDE);
        sq2 = sq1 || (i_ch == CH_QUOTE);

        rec_b.head  = head2;
        rec_b.len   = pl2;
        rec_b.col   = tsc2;
        rec_b.line  = ln2;
        rec_b.cut   = 1'b0;
        rec_b.last  = 1'b1;
        rec_b.tilde = st2;
        rec_b.quote = sq2;

        // Flush on end of text
        col_sum2 = {1'b0, cc2} + (COL_W+1)'(pl2);
        n_tsc = tsc2;
        n_ln  = ln2;
        if (i_eot) begin
            n_cc   = col_sum2[COL_W] ? '1 : col_sum2[COL_W-1:0];
            n_pl   = '0;
            n_head = '0;
            n_st   = 1'b0;
            n_sq   = 1'b0;
            n_qm   = QM_NONE;
            n_prev = '0;
        end else begin
            n_cc   = cc2;
            n_pl   = pl2;
            n_head = head2;
            n_st   = st2;
            n_sq   = sq2;
            n_qm   = qm2;
            n_prev = i_ch;
        end
    end

    // Order records so the first slot is always filled first
    assign o_push.first  = i_take && (emit1 || i_eot);
    assign o_push.second = i_take && emit1 && i_eot;
    assign o_rec0        = emit1 ? rec_a : rec_b;
    assign o_rec1        = rec_b;

    // Advance state on a transfer; load the line on a config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_pl   <= '0;
            r_prev <= '0;
            r_qm   <= QM_NONE;
            r_st   <= 1'b0;
            r_sq   <= 1'b0;
            r_tsc  <= '0;
            r_cc   <= '0;
            r_ln   <= '0;
        end else if (i_cfg_we) begin
            r_ln <= i_cfg_wdata;
        end else if (i_take) begin
            r_head <= n_head;
            r_pl   <= n_pl;
            r_prev <= n_prev;
            r_qm   <= n_qm;
            r_st   <= n_st;
            r_sq   <= n_sq;
            r_tsc  <= n_tsc;
            r_cc   <= n_cc;
            r_ln   <= n_ln;
        end
    end

endmodule

`default_nettype wire

[src/stt_queue.sv]
// ----------------------------------------------------------------------------
// stt_queue: raw token queue
// Small FIFO that absorbs up to two records per cycle and releases one.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire stt_pkg::t_push i_push,
    input  wire stt_pkg::t_raw  i_rec0,
    input  wire stt_pkg::t_raw  i_rec1,
    input  wire logic    i_pop,
    output stt_pkg::t_raw  o_head,
    output logic         o_nonempty,
    output logic         o_busy
);
    import stt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_raw             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] wptr_next;

    assign wptr_next = r_wptr + PTR_W'(1);

    always_comb begin
        n_wptr  = r_wptr + PTR_W'(i_push.first) + PTR_W'(i_push.second);
        n_rptr  = r_rptr + PTR_W'(i_pop);
        n_count = r_count + CNT_W'(i_push.first) + CNT_W'(i_push.second)
                  - CNT_W'(i_pop);
    end

    // Write new records
    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_wptr] <= i_rec0;
        end
        if (i_push.second) begin
            r_mem[wptr_next] <= i_rec1;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    assign o_head     = r_mem[r_rptr];
    assign o_nonempty = (r_count != '0);
    // Hold off input while fewer than two slots are free
    assign o_busy     = (r_count > CNT_W'(QUEUE_DEPTH - 2));

endmodule

`default_nettype wire

[src/stt_emit.sv]
// ----------------------------------------------------------------------------
// stt_emit: classification and output register
// Classifies the queue head and holds the result until it is transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_emit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire stt_pkg::t_raw               i_head,
    input  wire logic                        i_nonempty,
    output logic                             o_pop,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [stt_pkg::TYPE_W-1:0]       o_token_type,
    output logic [stt_pkg::LEN_W-1:0]        o_token_length,
    output logic [stt_pkg::COL_W-1:0]        o_token_column,
    output logic [stt_pkg::LINE_W-1:0]       o_token_line,
    output logic                             o_was_cut,
    output logic                             o_last_token
);
    import stt_pkg::*;

    logic              r_valid;
    logic [TYPE_W-1:0] r_type;
    logic [LEN_W-1:0]  r_len;
    logic [COL_W-1:0]  r_col;
    logic [LINE_W-1:0] r_line;
    logic              r_cut;
    logic              r_last;
    logic [TYPE_W-1:0] n_type;

    assign n_type = classify(i_head);
    // Load when the register is empty or its result is being taken
    assign o_pop  = i_nonempty && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_nonempty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_type <= n_type;
            r_len  <= i_head.len;
            r_col  <= i_head.col;
            r_line <= i_head.line;
            r_cut  <= i_head.cut;
            r_last <= i_head.last;
        end
    end

    assign o_valid        = r_valid;
    assign o_token_type   = r_type;
    assign o_token_length = r_len;
    assign o_token_column = r_col;
    assign o_token_line   = r_line;
    assign o_was_cut      = r_cut;
    assign o_last_token   = r_last;

endmodule

`default_nettype wire

[bench/stt_token_checker.sv]
// ----------------------------------------------------------------------------
// stt_token_checker: token stream predictor and scoreboard
// Watches the character and token channels of the tokenizer, keeps its own
// model of the scanner state, and compares every token transfer field by
// field with the oldest predicted token. Hands back a mismatch count.
// ----------------------------------------------------------------------------

module stt_token_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_stall,
    input  wire logic [stt_pkg::CH_W-1:0]    i_ch,
    input  wire logic                        i_end_of_text,
    input  wire logic                        i_cfg_we,
    input  wire logic [stt_pkg::LINE_W-1:0]  i_cfg_wdata,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_stall,
    input  wire logic [stt_pkg::TYPE_W-1:0]  i_token_type,
    input  wire logic [stt_pkg::LEN_W-1:0]   i_token_length,
    input  wire logic [stt_pkg::COL_W-1:0]   i_token_column,
    input  wire logic [stt_pkg::LINE_W-1:0]  i_token_line,
    input  wire logic                        i_was_cut,
    input  wire logic                        i_last_token,
    output int                               o_fail_count,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    localparam int PRINT_LIMIT = 100;

    typedef struct packed {
        logic [TYPE_W-1:0] kind;
        logic [LEN_W-1:0]  len;
        logic [COL_W-1:0]  col;
        logic [LINE_W-1:0] line;
        logic              cut;
        logic              last;
    } token_t;

    // Keywords in priority order; the first full match names the token
    string keyword_list [19] = '{
        "include", "byte", "char", "int", "prec", "bool", "true", "false",
        "string", "function", "returns", "return", "while", "still", "do",
        "loop", "for", "static", "end"
    };

    token_t            expected_tokens [$];
    token_t            want;
    int                fail_total;
    int                tokens_seen;

    // Scanner state as the predictor sees it
    logic [HEAD_W-1:0] held_chars;
    int unsigned       pend_len;
    logic [CH_W-1:0]   prev_ch;
    logic [1:0]        mark_mode;
    bit                tilde_seen;
    bit                quote_seen;
    logic [COL_W-1:0]  start_col;
    logic [COL_W-1:0]  col_count;
    logic [LINE_W-1:0] line_no;

    function automatic bit breaks_token(input logic [CH_W-1:0] c);
        case (c)
            "{", "}", "[", "]", "(", ")", ".", ",", ":", ";": return 1'b1;
            "+", "-", "*", "/", "^", ">", "<":                return 1'b1;
            CH_TAB, CH_SPACE, CH_NL:                          return 1'b1;
            default:                                          return 1'b0;
        endcase
    endfunction

    function automatic logic [TYPE_W-1:0] token_kind();
        logic [TYPE_W-1:0] kind;
        bit                found;
        bit                hit;
        kind  = tilde_seen ? TT_COMMENT : (quote_seen ? TT_LITERAL : TT_IDENT);
        found = 1'b0;
        // Match keywords against the held head bytes only
        if (pend_len <= HEAD_BYTES) begin
            for (int k = 0; k < 19; k++) begin
                if (!found && keyword_list[k].len() == pend_len) begin
                    hit = 1'b1;
                    for (int j = 0; j < keyword_list[k].len(); j++) begin
                        if (held_chars[CH_W*j +: CH_W] != keyword_list[k][j]) hit = 1'b0;
                    end
                    if (hit) begin
                        kind  = TYPE_W'(TT_KW_BASE + k);
                        found = 1'b1;
                    end
                end
            end
        end
        // Single punctuation and whitespace tokens
        if (pend_len == 1) begin
            case (held_chars[CH_W-1:0])
                "{":      kind = TT_LBRACE;
                "}":      kind = TT_RBRACE;
                "[":      kind = TT_LBRACKET;
                "]":      kind = TT_RBRACKET;
                "(":      kind = TT_LPAREN;
                ")":      kind = TT_RPAREN;
                ".":      kind = TT_DOT;
                ",":      kind = TT_COMMA;
                ":":      kind = TT_COLON;
                ";":      kind = TT_SEMI;
                CH_EQ:    kind = TT_EQUALS;
                CH_TAB:   kind = TT_TAB;
                CH_SPACE: kind = TT_SPACE;
                CH_NL:    kind = TT_NEWLINE;
                default:  kind = kind;
            endcase
        end
        return kind;
    endfunction

    // Finish the pending token: build its record and advance the column
    function automatic token_t close_token(input bit cut, input bit last);
        token_t      t;
        int unsigned next_col;
        t.kind     = token_kind();
        t.len      = LEN_W'(pend_len);
        t.col      = start_col;
        t.line     = line_no;
        t.cut      = cut;
        t.last     = last;
        next_col   = col_count + pend_len;
        col_count  = (next_col > 32'hFFFF) ? 16'hFFFF : COL_W'(next_col);
        pend_len   = 0;
        held_chars = '0;
        tilde_seen = 1'b0;
        quote_seen = 1'b0;
        return t;
    endfunction

    // Advance the scanner by one character and queue the tokens it finishes
    task automatic predict_char(input logic [CH_W-1:0] c, input bit eot);
        bit         boundary;
        bit         cut;
        logic [1:0] held_mode;
        if (pend_len > 0) begin
            boundary = (mark_mode == QM_NONE) && (breaks_token(prev_ch) || breaks_token(c));
            cut      = !boundary && pend_len >= MAX_TOKEN;
            if (boundary || cut) begin
                held_mode = mark_mode;
                expected_tokens.push_back(close_token(cut, 1'b0));
                // A cut inside a comment or literal keeps its kind
                if (cut) begin
                    tilde_seen = (held_mode == QM_COMMENT);
                    quote_seen = (held_mode == QM_LITERAL);
                end
            end
        end
        // Take the character into the pending token
        if (pend_len == 0) begin
            if (c == CH_NL) begin
                if (line_no != '1) line_no = line_no + 1'b1;
                col_count = '0;
            end
            start_col  = col_count;
            held_chars = '0;
        end
        if (pend_len < HEAD_BYTES) held_chars[CH_W*pend_len +: CH_W] = c;
        pend_len++;
        if (mark_mode == QM_NONE) begin
            if (c == CH_TILDE) mark_mode = QM_COMMENT;
            else if (c == CH_QUOTE) mark_mode = QM_LITERAL;
        end else if (mark_mode == QM_COMMENT && c == CH_TILDE) begin
            mark_mode = QM_NONE;
        end else if (mark_mode == QM_LITERAL && c == CH_QUOTE) begin
            mark_mode = QM_NONE;
        end
        if (c == CH_TILDE) tilde_seen = 1'b1;
        if (c == CH_QUOTE) quote_seen = 1'b1;
        prev_ch = c;
        // Flush at end of text and close any open comment or literal
        if (eot) begin
            expected_tokens.push_back(close_token(1'b0, 1'b1));
            mark_mode = QM_NONE;
            prev_ch   = '0;
        end
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        fail_total++;
        if (fail_total <= PRINT_LIMIT) begin
            $display("%0t ns: token %0d: %s is %0d, expected %0d",
                     $realtime, tokens_seen, field, got, exp_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_chars = '0;
            pend_len   = 0;
            prev_ch    = '0;
            mark_mode  = QM_NONE;
            tilde_seen = 1'b0;
            quote_seen = 1'b0;
            start_col  = '0;
            col_count  = '0;
            line_no    = '0;
            expected_tokens.delete();
        end else begin
            // Load the start line into the running line number
            if (i_cfg_we) line_no = i_cfg_wdata;
            // Compare a token transfer with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch("token with none expected, type", 64'(i_token_type), 0);
                end else begin
                    want = expected_tokens.pop_front();
                    if (i_token_type !== want.kind)
                        report_mismatch("token_type", 64'(i_token_type), 64'(want.kind));
                    if (i_token_length !== want.len)
                        report_mismatch("token_length", 64'(i_token_length), 64'(want.len));
                    if (i_token_column !== want.col)
                        report_mismatch("token_column", 64'(i_token_column), 64'(want.col));
                    if (i_token_line !== want.line)
                        report_mismatch("token_line", 64'(i_token_line), 64'(want.line));
                    if (i_was_cut !== want.cut)
                        report_mismatch("was_cut", 64'(i_was_cut), 64'(want.cut));
                    if (i_last_token !== want.last)
                        report_mismatch("last_token", 64'(i_last_token), 64'(want.last));
                end
                tokens_seen++;
            end
            // Predict from a character transfer
            if (i_in_valid && !i_in_stall) predict_char(i_ch, i_end_of_text);
        end
        o_pending    <= expected_tokens.size();
        o_fail_count <= fail_total;
    end

endmodule

[bench/source_text_tokenizer_top_tb.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer_top_tb: testbench for the source text tokenizer
// Feeds directed and random source text through the character channel with
// random gaps and token-side stalls, moves the start line between phases,
// and takes the verdict from the token checker that sits beside the block.
// ----------------------------------------------------------------------------

module source_text_tokenizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int LONG_HOLD   = 200;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    logic [CH_W-1:0]     i_ch          = '0;
    logic                i_end_of_text = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic [LINE_W-1:0]   i_cfg_wdata   = '0;
    logic                i_stall       = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [TYPE_W-1:0]   o_token_type;
    logic [LEN_W-1:0]    o_token_length;
    logic [COL_W-1:0]    o_token_column;
    logic [LINE_W-1:0]   o_token_line;
    logic                o_was_cut;
    logic                o_last_token;

    int                  fail_count;
    int                  pending;
    int unsigned         cycle_count = 0;

    // Source text waiting to be sent, one end-of-text flag per character
    logic [CH_W-1:0]     text_chars [$];
    bit                  text_ends [$];

    source_text_tokenizer_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_ch           (i_ch),
        .i_end_of_text  (i_end_of_text),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_type   (o_token_type),
        .o_token_length (o_token_length),
        .o_token_column (o_token_column),
        .o_token_line   (o_token_line),
        .o_was_cut      (o_was_cut),
        .o_last_token   (o_last_token)
    );

    stt_token_checker token_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_ch           (i_ch),
        .i_end_of_text  (i_end_of_text),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_token_type   (o_token_type),
        .i_token_length (o_token_length),
        .i_token_column (o_token_column),
        .i_token_line   (o_token_line),
        .i_was_cut      (o_was_cut),
        .i_last_token   (o_last_token),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #5 i_clk = ~i_clk;

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic add_char(input logic [CH_W-1:0] c);
        text_chars.push_back(c);
        text_ends.push_back(1'b0);
    endtask

    function automatic logic [CH_W-1:0] word_char();
        string letters;
        letters = "abcdefghijklmnopqrstuvwxyz_0123456789";
        case ($urandom_range(0, 15))
            0:       return 8'h00;
            1, 2:    return 8'($urandom_range(128, 255));
            default: return letters[$urandom_range(0, letters.len() - 1)];
        endcase
    endfunction

    // Any character that does not close the open comment or literal
    function automatic logic [CH_W-1:0] body_char(input logic [CH_W-1:0] mark,
                                                  input bit allow_nl);
        string           pool;
        logic [CH_W-1:0] c;
        pool = "ab z+;~\"\t.q";
        do begin
            if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(0, 255));
            else c = pool[$urandom_range(0, pool.len() - 1)];
        end while (c == mark || (!allow_nl && c == CH_NL));
        return c;
    endfunction

    // Append one token's worth of text, mostly well formed
    task automatic add_token(input bit allow_nl);
        int              pick;
        int              n;
        int              k;
        logic [CH_W-1:0] c;
        string           punct;
        punct = "{}[]().,:;=+-*/^><";
        pick  = $urandom_range(0, 99);
        if (pick < 22) begin
            // keyword, often fenced by delimiters, sometimes with a tail that spoils it
            k = $urandom_range(0, KW_COUNT - 1);
            if ($urandom_range(0, 1)) add_char(CH_SPACE);
            for (int j = 0; j < KW_LEN[k]; j++)
                add_char(KW_TEXT[k][CH_W*(KW_LEN[k]-1-j) +: CH_W]);
            if ($urandom_range(0, 3) == 0) add_char(word_char());
            if ($urandom_range(0, 1)) add_char(punct[$urandom_range(0, punct.len() - 1)]);
        end else if (pick < 42) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 45) : $urandom_range(1, 10);
            repeat (n) add_char(word_char());
        end else if (pick < 57) begin
            add_char(punct[$urandom_range(0, punct.len() - 1)]);
        end else if (pick < 70) begin
            case ($urandom_range(0, 2))
                0:       add_char(CH_SPACE);
                1:       add_char(CH_TAB);
                default: add_char(allow_nl ? CH_NL : CH_SPACE);
            endcase
        end else if (pick < 90) begin
            // comment or literal; now and then the text ends while it is open
            c = (pick < 80) ? CH_TILDE : CH_QUOTE;
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 45) : $urandom_range(0, 8);
            add_char(c);
            repeat (n) add_char(body_char(c, allow_nl));
            if ($urandom_range(0, 9) == 0) text_ends[text_ends.size() - 1] = 1'b1;
            else add_char(c);
        end else if (pick < 97) begin
            c = 8'($urandom_range(0, 255));
            if (!allow_nl && c == CH_NL) c = CH_SPACE;
            add_char(c);
        end else if (text_ends.size() > 0) begin
            text_ends[text_ends.size() - 1] = 1'b1;
        end
    endtask

    // Offer every queued character, with random gaps in stretches
    task automatic send_text(input int max_gap);
        int gap;
        int gap_top;
        gap_top = max_gap;
        for (int i = 0; i < text_chars.size(); i++) begin
            if (i % 50 == 0) gap_top = $urandom_range(0, 1) ? max_gap : 0;
            gap = $urandom_range(0, gap_top);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid       <= 1'b1;
            i_ch          <= text_chars[i];
            i_end_of_text <= text_ends[i];
            do @(posedge i_clk); while (o_stall);
        end
        i_valid <= 1'b0;
        text_chars.delete();
        text_ends.delete();
    endtask

    // Hold off until every token has arrived and the pipeline has emptied
    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_start_line(input logic [LINE_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [LINE_W-1:0] first_line, input int n_chars,
                             input int max_gap, input bit allow_nl);
        wait_drained();
        write_start_line(first_line);
        while (text_chars.size() < n_chars) add_token(allow_nl);
        text_ends[text_ends.size() - 1] = 1'b1;
        send_text(max_gap);
    endtask

    // Token side: random stalls per transfer, with a few long hold-offs
    initial begin
        int wait_cycles;
        int wait_top;
        int rx_count;
        rx_count = 0;
        wait_top = 4;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_count % 64 == 0) wait_top = $urandom_range(0, 1) ? 4 : 0;
            if (rx_count == 100 || rx_count == 700 || rx_count == 3000)
                wait_cycles = LONG_HOLD;
            else
                wait_cycles = $urandom_range(0, wait_top);
            if (wait_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            rx_count++;
        end
    end

    // Character side and verdict
    initial begin
        string directed;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every single-character kind, marks inside the other mark, zero and top bytes,
        // and a comment still open at end of text
        wait_drained();
        write_start_line('0);
        directed = "{}[]().,:;=\t \n<~\"~ \"~\"";
        for (int i = 0; i < directed.len(); i++) add_char(directed[i]);
        add_char(8'h00);
        add_char(8'hFF);
        add_char(";");
        add_char(CH_TILDE);
        add_char("a");
        text_ends[text_ends.size() - 1] = 1'b1;
        send_text(4);

        // Line number at and near the top, then random settings
        run_phase('1, 250, 4, 1'b1);
        run_phase(20'hFFFFD, 250, 4, 1'b1);
        run_phase(LINE_W'($urandom_range(0, 20'hFFFFF)), 400, 4, 1'b1);
        // One line with no newline, sent back to back
        run_phase('0, 300, 0, 1'b0);
        run_phase(LINE_W'($urandom_range(0, 20'hFFFFF)), 250, 4, 1'b1);

        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
